FILE: design/ryc_pkg.sv
// ryc_pkg: shared types and constants for the rgb to ycbcr 4:2:0 converter
// payload structs, register indexes, reset values and bt.709 coefficients
// no dependencies
package ryc_pkg;

  // configuration register file
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd1080;
  localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT   = 13'd4096;

  // position counters wrap at 12 bits
  localparam int unsigned POS_W = 12;

  // per-channel sum widths: pair of pixels, then 2x2 block
  localparam int unsigned PAIR_W  = 9;
  localparam int unsigned BLOCK_W = 10;
  localparam int unsigned LINE_W  = 3 * PAIR_W;

  // luma coefficients, 16-bit fractions
  localparam logic [15:0] Y_R = 16'd13933;
  localparam logic [15:0] Y_G = 16'd46871;
  localparam logic [15:0] Y_B = 16'd4732;

  // chroma coefficients on 4-pixel sums, result shifted by 18
  localparam logic [15:0] CB_R = 16'd7510;
  localparam logic [15:0] CB_G = 16'd25258;
  localparam logic [15:0] CR_G = 16'd29766;
  localparam logic [15:0] CR_B = 16'd3002;
  localparam logic [15:0] C_HALF = 16'd32768;
  localparam int unsigned C_OFFSET = 33554432;  // 128 in the scaled domain
  localparam int unsigned C_SHIFT  = 18;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_value;
    logic [7:0] cr_value;
    logic       end_of_frame;
  } result_t;

  // block sums of one 2x2 group, one per channel
  typedef struct packed {
    logic [BLOCK_W-1:0] sum_r;
    logic [BLOCK_W-1:0] sum_g;
    logic [BLOCK_W-1:0] sum_b;
  } block_sum_t;

endpackage

FILE: design/rgb_to_ycbcr420_converter_core.sv
// rgb_to_ycbcr420_converter_core: streaming rgb to ycbcr 4:2:0 converter, bt.709
// top level with position counters, held left pixel, pair-sum line store and pipeline
// depends on ryc_pkg and ryc_csc

// Takes one 8-bit rgb pixel per transfer in raster order and returns one result per
// pixel: its full-range bt.709 luma, and at the bottom-right pixel of every aligned
// 2x2 block (odd column of an odd row) also cb and cr of the block's mean color; cb
// and cr read zero elsewhere, and end_of_frame marks the frame's last pixel. The
// block sustains one pixel per clock while the output is not stalled: every pixel
// passes a capture stage (counters, pair sums, line store access) and a math stage that
// loads the output register, so a result is held in the capture register and then in
// the output register. The capture stage doubles as a skid slot, so an input transfer
// can still happen while a result waits. The line store holds MAX_WIDTH/2 entries of
// 27 bits (three 9-bit pair sums of the last even row) and is read with a registered
// port; it has no clearing pass, as every entry is written in an even row before the
// odd row reads it. frame_width and frame_height may only be written while the block
// is idle; 0 acts as 1 and values above MAX_WIDTH (width) or 4096 (height) are
// clamped. On an odd width or height the last column or row gives luma only.
module rgb_to_ycbcr420_converter_core import ryc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pixel_t                in_data_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_data_o
);

  localparam int unsigned DEPTH  = MAX_WIDTH / 2;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // wide enough for the register value and for MAX_WIDTH itself
  localparam int unsigned SW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                               $clog2(MAX_WIDTH + 1) : CFG_DATA_W;

  // what the capture stage hands to the math stage
  typedef struct packed {
    pixel_t            pix;
    logic [PAIR_W-1:0] pair_r;
    logic [PAIR_W-1:0] pair_g;
    logic [PAIR_W-1:0] pair_b;
    logic              chroma;
    logic              eof;
  } stage_t;

  // configuration registers
  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;

  // position and held pixel
  logic [POS_W-1:0] col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;
  pixel_t           held_q;

  // pipeline
  logic    s1_valid_q;
  stage_t  s1_q, s1_d;
  logic    out_valid_q;
  result_t out_q;

  // line store
  logic [LINE_W-1:0] pair_sum_line [DEPTH];
  logic [LINE_W-1:0] line_rd_q;
  logic [ADDR_W-1:0] slot;
  logic              line_we;
  logic              line_re;

  logic in_xfer;
  logic advance;

  logic [SW-1:0]         width_eff;
  logic [SW-1:0]         col_next_ext;
  logic [CFG_DATA_W-1:0] height_eff;
  logic [CFG_DATA_W-1:0] row_next_ext;
  logic                  row_end;
  logic                  frame_end;
  logic                  odd_col;
  logic                  odd_row;

  block_sum_t block_sum;
  logic [7:0] luma;
  logic [7:0] cb;
  logic [7:0] cr;

  // ---------------------------------------------------------------------------
  // handshake: the output register drains or is empty, then everything moves
  // ---------------------------------------------------------------------------
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IDX_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // effective frame size and row / frame end detection
  // ---------------------------------------------------------------------------
  always_comb begin
    if (width_q == '0) begin
      width_eff = SW'(1);
    end else if (SW'(width_q) > SW'(MAX_WIDTH)) begin
      width_eff = SW'(MAX_WIDTH);
    end else begin
      width_eff = SW'(width_q);
    end

    if (height_q == '0) begin
      height_eff = CFG_DATA_W'(1);
    end else if (height_q > MAX_HEIGHT) begin
      height_eff = MAX_HEIGHT;
    end else begin
      height_eff = height_q;
    end
  end

  // x >= w-1 is checked as x+1 >= w, which has no underflow
  assign col_next_ext = SW'(col_q) + SW'(1);
  assign row_next_ext = CFG_DATA_W'(row_q) + CFG_DATA_W'(1);
  assign row_end      = col_next_ext >= width_eff;
  assign frame_end    = row_end && (row_next_ext >= height_eff);
  assign odd_col      = col_q[0];
  assign odd_row      = row_q[0];

  always_comb begin
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_next_ext[POS_W-1:0];
    end else begin
      col_d = col_next_ext[POS_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
      // even column: keep the pixel as the left half of the next pair
      if (!odd_col) begin
        held_q <= in_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // capture stage: horizontal pair sums against the held left pixel
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_d.pix    = in_data_i;
    s1_d.pair_r = PAIR_W'(in_data_i.red)   + PAIR_W'(held_q.red);
    s1_d.pair_g = PAIR_W'(in_data_i.green) + PAIR_W'(held_q.green);
    s1_d.pair_b = PAIR_W'(in_data_i.blue)  + PAIR_W'(held_q.blue);
    s1_d.chroma = odd_col && odd_row;
    s1_d.eof    = frame_end;
  end

  // line store: even rows write pair sums, odd rows read them back
  assign slot    = ADDR_W'(col_q >> 1);
  assign line_we = in_xfer && odd_col && !odd_row;
  assign line_re = in_xfer && odd_col && odd_row;

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      pair_sum_line[slot] <= {s1_d.pair_r, s1_d.pair_g, s1_d.pair_b};
    end
    if (line_re) begin
      line_rd_q <= pair_sum_line[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // math stage: 2x2 block sums, color conversion, output register
  // ---------------------------------------------------------------------------
  assign block_sum.sum_r = BLOCK_W'(s1_q.pair_r) + BLOCK_W'(line_rd_q[3*PAIR_W-1:2*PAIR_W]);
  assign block_sum.sum_g = BLOCK_W'(s1_q.pair_g) + BLOCK_W'(line_rd_q[2*PAIR_W-1:PAIR_W]);
  assign block_sum.sum_b = BLOCK_W'(s1_q.pair_b) + BLOCK_W'(line_rd_q[PAIR_W-1:0]);

  ryc_csc u_csc (
    .pix_i  (s1_q.pix),
    .sum_i  (block_sum),
    .luma_o (luma),
    .cb_o   (cb),
    .cr_o   (cr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_q.luma         <= luma;
      out_q.chroma_valid <= s1_q.chroma;
      out_q.cb_value     <= s1_q.chroma ? cb : 8'd0;
      out_q.cr_value     <= s1_q.chroma ? cr : 8'd0;
      out_q.end_of_frame <= s1_q.eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/ryc_csc.sv
// ryc_csc: bt.709 full-range color math, luma of one pixel and chroma of a 2x2 sum
// purely combinational, truncating then clamping to 0..255
// depends on ryc_pkg
module ryc_csc import ryc_pkg::*; (
  input  pixel_t     pix_i,
  input  block_sum_t sum_i,
  output logic [7:0] luma_o,
  output logic [7:0] cb_o,
  output logic [7:0] cr_o
);

  logic [24:0]        luma_acc;
  logic signed [28:0] cb_acc;
  logic signed [28:0] cr_acc;
  logic signed [28:0] cb_shift;
  logic signed [28:0] cr_shift;

  function automatic logic [7:0] clamp_byte(input logic signed [28:0] v);
    logic [7:0] res;
    if (v < 29'sd0) begin
      res = 8'd0;
    end else if (v > 29'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // sum of coefficients is 65536, so luma never exceeds 255 but clamp anyway
  assign luma_acc = 25'(Y_R) * 25'(pix_i.red)
                  + 25'(Y_G) * 25'(pix_i.green)
                  + 25'(Y_B) * 25'(pix_i.blue);
  assign luma_o   = (luma_acc[24:16] > 9'd255) ? 8'd255 : luma_acc[23:16];

  assign cb_acc = 29'(C_OFFSET)
                + $signed(29'(C_HALF) * 29'(sum_i.sum_b))
                - $signed(29'(CB_R) * 29'(sum_i.sum_r))
                - $signed(29'(CB_G) * 29'(sum_i.sum_g));
  assign cr_acc = 29'(C_OFFSET)
                + $signed(29'(C_HALF) * 29'(sum_i.sum_r))
                - $signed(29'(CR_G) * 29'(sum_i.sum_g))
                - $signed(29'(CR_B) * 29'(sum_i.sum_b));

  // arithmetic shift floors toward minus infinity
  assign cb_shift = cb_acc >>> C_SHIFT;
  assign cr_shift = cr_acc >>> C_SHIFT;

  assign cb_o = clamp_byte(cb_shift);
  assign cr_o = clamp_byte(cr_shift);

endmodule
